>>> rtl/core/dops_pkg.sv
// ----------------------------------------------------------------------------
// dops_pkg
// Shared types and constants for the depth occlusion pixel shader core.
// ----------------------------------------------------------------------------
package dops_pkg;

    localparam int MAX_FRAME_PIXELS = 65536;
    localparam int WIN_LEN          = 5;
    localparam int IDX_W            = $clog2(MAX_FRAME_PIXELS);
    localparam int CFG_W            = 17;
    // wide enough for the frame length register and for index plus window length
    localparam int CMP_BASE_W       = $clog2(MAX_FRAME_PIXELS + WIN_LEN) + 1;
    localparam int CMP_W            = (CMP_BASE_W > CFG_W + 1) ? CMP_BASE_W : CFG_W + 1;
    localparam int SUB_W            = 6;
    localparam int FRAME_RESET      = 16384;
    localparam int ADDR_W           = 3;

    localparam logic REG_FRAME_PIXELS = 1'b0;
    localparam logic [7:0] PIX_MAX    = 8'd255;

    typedef struct packed {
        logic [7:0] depth_value;
        logic [7:0] pixel_value;
    } pix_word_t;

    typedef struct packed {
        logic [7:0] shaded_value;
        logic       frame_end;
    } shade_word_t;

    // darkening step for an earlier pixel at distance k+1
    function automatic logic [SUB_W-1:0] darken_by(input logic [2:0] k);
        logic [SUB_W-1:0] d;
        case (k)
            3'd0:    d = SUB_W'(3);
            3'd1:    d = SUB_W'(7);
            3'd2:    d = SUB_W'(10);
            3'd3:    d = SUB_W'(15);
            3'd4:    d = SUB_W'(7);
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/core/depth_occlusion_pixel_shade_core.sv
// ----------------------------------------------------------------------------
// depth_occlusion_pixel_shade_core
// Darkens each pixel by nearer earlier pixels in a five-wide depth window and
// brightens it by its own depth, one raster-ordered frame at a time.
// ----------------------------------------------------------------------------
// an accepted word is registered into the output register, or into the skid
// register under stall; throughput: one word per cycle while not stalled,
// set by the single-pass shade logic feeding the output register
// reset: window and pixel index cleared, frame_pixels back to 16384,
// output and skid empty
module depth_occlusion_pixel_shade_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  dops_pkg::pix_word_t                pix_data,
    output logic                               shade_valid,
    input  logic                               shade_stall,
    output dops_pkg::shade_word_t              shade_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dops_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [dops_pkg::CFG_W-1:0]  frame_pixels_reg;
    logic [7:0]                  window_reg [dops_pkg::WIN_LEN];
    logic [dops_pkg::IDX_W-1:0]  idx_reg;
    logic                        out_valid_reg;
    dops_pkg::shade_word_t       out_reg;
    logic                        skid_valid_reg;
    dops_pkg::shade_word_t       skid_reg;

    logic                        cfg_write;
    logic                        in_fire;
    logic                        out_fire;
    logic [dops_pkg::CMP_W-1:0]  frame_len;
    logic [dops_pkg::CMP_W-1:0]  idx_ext;
    logic                        last_pix;
    logic [7:0]                  eff_depth;
    logic [dops_pkg::SUB_W-1:0]  sub_sum;
    logic [7:0]                  darkened;
    logic [8:0]                  bright_sum;
    dops_pkg::shade_word_t       result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == dops_pkg::REG_FRAME_PIXELS)
                       ? 32'(frame_pixels_reg) : 32'd0;

    assign pix_stall   = skid_valid_reg;
    assign in_fire     = pix_valid && !skid_valid_reg;
    assign out_fire    = out_valid_reg && !shade_stall;
    assign shade_valid = out_valid_reg;
    assign shade_data  = out_reg;

    // frame length with zero read as one and clamp at the maximum
    always_comb
    begin
        if (frame_pixels_reg == '0)
            frame_len = dops_pkg::CMP_W'(1);
        else if (dops_pkg::CMP_W'(frame_pixels_reg) > dops_pkg::CMP_W'(dops_pkg::MAX_FRAME_PIXELS))
            frame_len = dops_pkg::CMP_W'(dops_pkg::MAX_FRAME_PIXELS);
        else
            frame_len = dops_pkg::CMP_W'(frame_pixels_reg);
    end

    assign idx_ext  = dops_pkg::CMP_W'(idx_reg);
    assign last_pix = (idx_ext + dops_pkg::CMP_W'(1)) >= frame_len;
    // tail of the frame carries no depth
    assign eff_depth = ((idx_ext + dops_pkg::CMP_W'(dops_pkg::WIN_LEN)) >= frame_len)
                       ? 8'd0 : pix_data.depth_value;

    always_comb
    begin
        sub_sum = '0;
        for (int k = 0; k < dops_pkg::WIN_LEN; k++)
        begin
            if (window_reg[k] > pix_data.depth_value)
                sub_sum = sub_sum + dops_pkg::darken_by(3'(k));
        end
    end

    always_comb
    begin
        if (pix_data.pixel_value > 8'(sub_sum))
            darkened = pix_data.pixel_value - 8'(sub_sum);
        else
            darkened = 8'd0;
        bright_sum = {1'b0, darkened} + {1'b0, eff_depth};
        result.shaded_value = bright_sum[8] ? dops_pkg::PIX_MAX : bright_sum[7:0];
        result.frame_end    = last_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_pixels_reg <= dops_pkg::CFG_W'(dops_pkg::FRAME_RESET);
        else if (cfg_write && paddr[2] == dops_pkg::REG_FRAME_PIXELS)
            frame_pixels_reg <= pwdata[dops_pkg::CFG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int k = 0; k < dops_pkg::WIN_LEN; k++)
                window_reg[k] <= 8'd0;
        end
        else if (in_fire)
        begin
            if (last_pix)
            begin
                idx_reg <= '0;
                for (int k = 0; k < dops_pkg::WIN_LEN; k++)
                    window_reg[k] <= 8'd0;
            end
            else
            begin
                idx_reg <= idx_reg + dops_pkg::IDX_W'(1);
                window_reg[0] <= eff_depth;
                for (int k = 1; k < dops_pkg::WIN_LEN; k++)
                    window_reg[k] <= window_reg[k-1];
            end
        end
    end

    // output register plus one skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_fire;
        end
        else if (in_fire)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_fire)
                out_reg <= result;
        end
        else if (in_fire)
            skid_reg <= result;
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_idx_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_pix) |=> (idx_reg == '0))
        else $error("pixel index not cleared after frame end");

    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_pix) |=> (window_reg[0] == 8'd0 && window_reg[4] == 8'd0))
        else $error("depth window not cleared at frame start");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !last_pix) |=> (idx_reg == $past(idx_reg) + dops_pkg::IDX_W'(1)))
        else $error("pixel index did not advance");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("accepted word did not reach the output register");

endmodule

>>> verif/depth_occlusion_pixel_shade_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_occlusion_pixel_shade_core_tb
// Streams raster-ordered depth/pixel words through the shader core with random
// gaps and output stalls. A scoreboard keeps its own five-deep depth history
// and frame position, predicts each shaded word, and compares it field by
// field. The frame length register is rewritten between phases, including
// degenerate, short and oversized frames.
// ----------------------------------------------------------------------------
module depth_occlusion_pixel_shade_core_tb;

    localparam int PHASE_WORDS = 72;
    localparam int HOLD_CYCLES = 80;

    class shade_scoreboard;
        logic [dops_pkg::CFG_W-1:0] frame_cfg = dops_pkg::CFG_W'(dops_pkg::FRAME_RESET);
        logic [7:0]       depth_hist [dops_pkg::WIN_LEN] = '{default: 8'd0};
        int unsigned      pos_in_frame = 0;
        int unsigned      darken_step [dops_pkg::WIN_LEN] = '{3, 7, 10, 15, 7};
        dops_pkg::shade_word_t pending [$];
        int               mismatches = 0;

        function void set_frame_pixels(input logic [dops_pkg::CFG_W-1:0] v);
            frame_cfg = v;
        endfunction

        function void note_pixel(input dops_pkg::pix_word_t w);
            int unsigned len;
            int unsigned drop;
            int unsigned eff;
            int unsigned val;
            dops_pkg::shade_word_t want;
            len = frame_cfg;
            if (len == 0)
                len = 1;
            if (len > dops_pkg::MAX_FRAME_PIXELS)
                len = dops_pkg::MAX_FRAME_PIXELS;
            drop = 0;
            for (int k = 0; k < dops_pkg::WIN_LEN; k++)
                if (depth_hist[k] > w.depth_value)
                    drop += darken_step[k];
            val = w.pixel_value;
            val = (val > drop) ? val - drop : 0;
            // the tail of a frame neither brightens nor shadows
            eff = (pos_in_frame + dops_pkg::WIN_LEN >= len) ? 0 : w.depth_value;
            if (eff != 0)
            begin
                val += eff;
                if (val > 255)
                    val = 255;
            end
            want.shaded_value = val[7:0];
            want.frame_end    = (pos_in_frame + 1 >= len);
            if (want.frame_end)
            begin
                depth_hist   = '{default: 8'd0};
                pos_in_frame = 0;
            end
            else
            begin
                for (int k = dops_pkg::WIN_LEN - 1; k > 0; k--)
                    depth_hist[k] = depth_hist[k-1];
                depth_hist[0] = eff[7:0];
                pos_in_frame++;
            end
            pending.push_back(want);
        endfunction

        function void check_shade(input dops_pkg::shade_word_t got);
            dops_pkg::shade_word_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: shade word %h with none expected", $time, got);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.shaded_value !== want.shaded_value)
            begin
                $display("%0t: shaded_value expected %0d actual %0d",
                         $time, want.shaded_value, got.shaded_value);
                mismatches++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $display("%0t: frame_end expected %0d actual %0d",
                         $time, want.frame_end, got.frame_end);
                mismatches++;
            end
        endfunction
    endclass

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        pix_valid   = 1'b0;
    logic                        pix_stall;
    dops_pkg::pix_word_t         pix_data    = '0;
    logic                        shade_valid;
    logic                        shade_stall = 1'b0;
    dops_pkg::shade_word_t       shade_data;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [dops_pkg::ADDR_W-1:0] paddr       = '0;
    logic [31:0]                 pwdata      = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    shade_scoreboard sb = new;

    int src_idle  = 0;
    int snk_idle  = 0;
    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;
    int hold_ctr  = 0;

    // frame_pixels per phase: degenerate, short, around the window, huge and clamped
    int phase_cfg [13] = '{6, 1, 2, 5, 65536, 7, 0, 9, 131071, 16, 3, 33, 65537};

    // one frame of 12, a word of the next frame, then a short frame and length 0
    logic [7:0] dir_depth [19] = '{200, 180, 160, 140, 120, 0, 255, 0, 1, 0, 0, 255,
                                   10, 255, 128, 0, 255, 77, 255};
    logic [7:0] dir_pixel [19] = '{100, 3, 50, 7, 0, 42, 255, 255, 1, 128, 2, 0,
                                   20, 255, 7, 0, 1, 88, 255};

    depth_occlusion_pixel_shade_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_data    (pix_data),
        .shade_valid (shade_valid),
        .shade_stall (shade_stall),
        .shade_data  (shade_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // output stall, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            shade_stall <= 1'b1;
            hold_ctr++;
            if (hold_ctr >= HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else
            shade_stall <= ($urandom_range(99) < snk_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && shade_valid === 1'b1 && shade_stall === 1'b0)
            sb.check_shade(shade_data);
    end

    task automatic send_pixel(input dops_pkg::pix_word_t w);
        while ($urandom_range(99) < src_idle)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= w;
        do
            @(posedge clk);
        while (pix_stall !== 1'b0);
        sb.note_pixel(w);
    endtask

    task automatic drain_shader();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frame_pixels(input logic [dops_pkg::CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dops_pkg::ADDR_W'(4 * int'(dops_pkg::REG_FRAME_PIXELS));
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_frame_pixels(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly descending ramps so nearer earlier pixels shadow later ones
    function automatic logic [7:0] pick_depth(input logic [7:0] prev);
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 2)
            return 8'd0;
        if (sel < 5)
            return 8'($urandom);
        if (prev > 8'd40)
            return prev - 8'($urandom_range(40));
        return 8'($urandom_range(255, 150));
    endfunction

    function automatic logic [7:0] pick_pixel();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 2)
            return 8'($urandom_range(45));
        if (sel < 4)
            return 8'($urandom_range(255, 200));
        return 8'($urandom);
    endfunction

    initial
    begin
        dops_pkg::pix_word_t w;
        logic [7:0]          prev_depth;
        prev_depth = 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_frame_pixels(dops_pkg::CFG_W'(12));
        for (int i = 0; i < 19; i++)
        begin
            if (i == 13 || i == 17)
            begin
                pix_valid <= 1'b0;
                drain_shader();
                write_frame_pixels((i == 13) ? dops_pkg::CFG_W'(3) : dops_pkg::CFG_W'(0));
            end
            w.depth_value = dir_depth[i];
            w.pixel_value = dir_pixel[i];
            send_pixel(w);
        end

        for (int p = 0; p < 13; p++)
        begin
            pix_valid <= 1'b0;
            drain_shader();
            write_frame_pixels(dops_pkg::CFG_W'(phase_cfg[p]));
            if (p < 5)
            begin
                src_idle = 30;
                snk_idle = 60;
            end
            else if (p < 9)
            begin
                src_idle = 60;
                snk_idle = 30;
            end
            else
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (p == 9)
                hold_go = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                w.depth_value = pick_depth(prev_depth);
                w.pixel_value = pick_pixel();
                prev_depth    = w.depth_value;
                send_pixel(w);
            end
        end
        pix_valid <= 1'b0;

        drain_shader();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("depth_occlusion_pixel_shade_core test passed");
        else
            $display("depth_occlusion_pixel_shade_core test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("depth_occlusion_pixel_shade_core test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dops_pkg.sv
rtl/core/depth_occlusion_pixel_shade_core.sv
verif/depth_occlusion_pixel_shade_core_tb.sv
